// File: rtl/mndt_pkg.sv
// shared types and constants for the midi note duration tracker
// no dependencies; imported by every module of the block
`default_nettype none

package mndt_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SEND_MIDI         = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_CHANNEL      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOTES_PER_CHANNEL = 2'd2;

  localparam logic [6:0] ON_VELOCITY  = 7'd100;
  localparam logic [6:0] OFF_VELOCITY = 7'd0;
  localparam logic [3:0] ON_CODE      = 4'h9;
  localparam logic [3:0] OFF_CODE     = 4'h8;
  localparam logic [3:0] CHAN_MASK    = 4'hF;

  localparam logic [2:0] MOD_LAST_STEP = 3'd6;

  typedef enum logic {
    KIND_NOTE_ON,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  note;
    logic [15:0] duration;
  } item_t;

  typedef struct packed {
    logic       send_midi;
    logic [3:0] base_channel;
    logic [4:0] notes_per_channel;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/mndt_front.sv
// front end: accepts input items, classifies them and drops out-of-range note-ons
// depends on mndt_pkg
`default_nettype none

module mndt_front #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           mode,
  input  wire logic [6:0]     note,
  input  wire logic [15:0]    duration_ticks,
  output logic                push_valid,
  input  wire logic           push_ready,
  output mndt_pkg::item_t     push_item
);
  import mndt_pkg::*;

  logic in_range;
  logic keep;

  always_comb begin
    in_range = {1'b0, note} < 8'(NOTE_COUNT);
    keep     = mode || in_range;
    in_ready = push_ready;
    push_valid = in_valid && keep;
    push_item.kind     = mode ? KIND_TICK : KIND_NOTE_ON;
    push_item.note     = note;
    push_item.duration = duration_ticks;
  end

endmodule

`default_nettype wire

// File: rtl/mndt_queue.sv
// two-entry item queue between front and back end
// depends on mndt_pkg
`default_nettype none

module mndt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire mndt_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output mndt_pkg::item_t     pop_item
);
  import mndt_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    push_ready = count != 2'd2;
    pop_valid  = count != 2'd0;
    pop_item   = entries[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

// File: rtl/mndt_back.sv
// back end: note table, expiry memory, tick scan, channel remainder and output register
// depends on mndt_pkg
`default_nettype none

module mndt_back #(
  parameter int unsigned NOTE_COUNT        = 128,
  parameter int unsigned TIME_BITS         = 32,
  parameter int unsigned MAX_OFFS_PER_TICK = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mndt_pkg::cfg_t  cfg,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire mndt_pkg::item_t pop_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           status_byte,
  output logic [6:0]           note_number,
  output logic [6:0]           velocity,
  output logic                 last
);
  import mndt_pkg::*;

  localparam int unsigned NB = $clog2(NOTE_COUNT);
  localparam int unsigned CW = $clog2(MAX_OFFS_PER_TICK + 1);
  localparam logic [NB:0]   NC_END  = (NB+1)'(NOTE_COUNT);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OFFS_PER_TICK);

  state_t state;
  state_t state_next;

  logic [NOTE_COUNT-1:0] sounding;
  logic [TIME_BITS-1:0]  expiry_mem [NOTE_COUNT];
  logic [TIME_BITS-1:0]  tick_now;

  logic [NB:0]           scan_idx;
  logic [4:0]            chan_issue;
  logic [4:0]            chan_issue_next;
  logic                  rd_valid;
  logic [NB-1:0]         rd_idx;
  logic [4:0]            rd_chan;
  logic [TIME_BITS-1:0]  rd_data;
  logic [CW-1:0]         cleared;

  logic [4:0]            rem;
  logic [5:0]            rem_shift;
  logic [4:0]            rem_next;
  logic [6:0]            mod_bits;
  logic [2:0]            step;
  logic [6:0]            item_note;

  logic                  hold_valid;
  logic [7:0]            hold_status;
  logic [6:0]            hold_note;
  logic [6:0]            hold_vel;

  logic [NB-1:0]         note_idx;
  logic                  mem_we;
  logic [TIME_BITS-1:0]  time_diff;
  logic                  expired;
  logic                  issuing;
  logic                  hit;
  logic                  slot_free;
  logic                  stall;
  logic                  advance;
  logic                  out_load;
  logic                  out_last;
  logic [3:0]            scan_chan;
  logic [3:0]            on_chan;

  always_comb begin
    note_idx  = pop_item.note[NB-1:0];
    time_diff = tick_now - rd_data;
    expired   = (time_diff != '0) && !time_diff[TIME_BITS-1];
    issuing   = scan_idx != NC_END;
    hit       = rd_valid && sounding[rd_idx] && expired && (cleared != MAX_CNT);
    slot_free = !out_valid || out_ready;
    rem_shift = {rem, mod_bits[6]};
    rem_next  = (rem_shift >= {1'b0, cfg.notes_per_channel}) ?
                5'(rem_shift - {1'b0, cfg.notes_per_channel}) : rem_shift[4:0];
    scan_chan = (cfg.notes_per_channel == 5'd0) ? cfg.base_channel : rd_chan[3:0] & CHAN_MASK;
    on_chan   = (cfg.notes_per_channel == 5'd0) ? cfg.base_channel : rem_next[3:0] & CHAN_MASK;
    if (cfg.notes_per_channel == 5'd0 || chan_issue == cfg.notes_per_channel - 5'd1) begin
      chan_issue_next = 5'd0;
    end else begin
      chan_issue_next = chan_issue + 5'd1;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    stall      = 1'b0;
    out_load   = 1'b0;
    out_last   = 1'b0;
    mem_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_item.kind == KIND_TICK) begin
            state_next = ST_SCAN;
          end else if (!sounding[note_idx]) begin
            mem_we = 1'b1;
            if (cfg.send_midi) state_next = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (step == MOD_LAST_STEP) state_next = ST_FLUSH;
      end
      ST_SCAN: begin
        if (cleared == MAX_CNT || (!issuing && !rd_valid)) begin
          state_next = ST_FLUSH;
        end else if (hit && cfg.send_midi && hold_valid) begin
          if (slot_free) out_load = 1'b1;
          else stall = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (hold_valid) begin
          if (slot_free) begin
            out_load   = 1'b1;
            out_last   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    advance = (state == ST_SCAN) && !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sounding   <= '0;
      tick_now   <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            if (pop_item.kind == KIND_TICK) begin
              tick_now <= tick_now + TIME_BITS'(1);
              rd_valid <= 1'b0;
            end else if (!sounding[note_idx]) begin
              sounding[note_idx] <= 1'b1;
            end
          end
        end
        ST_MOD: begin
          if (step == MOD_LAST_STEP) hold_valid <= 1'b1;
        end
        ST_SCAN: begin
          if (advance) rd_valid <= issuing;
          if (hit && !stall) begin
            sounding[rd_idx] <= 1'b0;
            if (cfg.send_midi) hold_valid <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (out_load) hold_valid <= 1'b0;
        end
        default: hold_valid <= hold_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        scan_idx   <= '0;
        chan_issue <= 5'd0;
        cleared    <= '0;
        rem        <= 5'd0;
        step       <= 3'd0;
        mod_bits   <= pop_item.note;
        item_note  <= pop_item.note;
      end
      ST_MOD: begin
        rem      <= rem_next;
        mod_bits <= {mod_bits[5:0], 1'b0};
        step     <= step + 3'd1;
        if (step == MOD_LAST_STEP) begin
          hold_status <= {ON_CODE, on_chan};
          hold_note   <= item_note;
          hold_vel    <= ON_VELOCITY;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          rd_idx  <= scan_idx[NB-1:0];
          rd_chan <= chan_issue;
          if (issuing) begin
            scan_idx   <= scan_idx + (NB+1)'(1);
            chan_issue <= chan_issue_next;
          end
        end
        if (hit && !stall) begin
          cleared <= cleared + CW'(1);
          hold_status <= {OFF_CODE, scan_chan};
          hold_note   <= 7'(rd_idx);
          hold_vel    <= OFF_VELOCITY;
        end
      end
      default: begin
        scan_idx <= scan_idx;
      end
    endcase
    if (out_load) begin
      status_byte <= hold_status;
      note_number <= hold_note;
      velocity    <= hold_vel;
      last        <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) expiry_mem[note_idx] <= tick_now + TIME_BITS'(pop_item.duration);
    if (advance && issuing) rd_data <= expiry_mem[scan_idx[NB-1:0]];
  end

endmodule

`default_nettype wire

// File: rtl/midi_note_duration_tracker_unit.sv
// midi note duration tracker: tracks sounding notes and emits note-on / note-off messages
// top level; depends on mndt_pkg, mndt_front, mndt_queue, mndt_back
//
// usage:
//   input channel (in_valid/in_ready, mode, note, duration_ticks): mode 0 asks for a
//   note-on, mode 1 is one time tick. output channel (out_valid/out_ready,
//   status_byte, note_number, velocity, last) carries midi messages; last marks the
//   final message of an item. the config port (cfg_write, cfg_index, cfg_data) writes
//   send_midi, base_channel and notes_per_channel with no wait.
//   a note-on runs a bit-serial remainder over the note number that picks the
//   channel. a tick scans the note table: the scan reads one expiry entry per cycle,
//   unless the output stalls, from the single-port expiry memory.
//   a two-entry queue sits between the input and the back end, so up to two items are
//   held while a tick is being scanned.
//   reset clears the note table, the tick counter and the registers to send_midi = 1,
//   base_channel = 0, notes_per_channel = 0; no clearing pass is needed.
//   when the receiver stalls, one message waits in the output register and one more in
//   a hold register, then the scan pauses until the output moves again.
`default_nettype none

module midi_note_duration_tracker_unit #(
  parameter int unsigned NOTE_COUNT        = 128,
  parameter int unsigned TIME_BITS         = 32,
  parameter int unsigned MAX_OFFS_PER_TICK = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [mndt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [mndt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 mode,
  input  wire logic [6:0]                           note,
  input  wire logic [15:0]                          duration_ticks,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [7:0]                                status_byte,
  output logic [6:0]                                note_number,
  output logic [6:0]                                velocity,
  output logic                                      last
);
  import mndt_pkg::*;

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_midi         <= 1'b1;
      cfg.base_channel      <= 4'd0;
      cfg.notes_per_channel <= 5'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEND_MIDI:         cfg.send_midi         <= cfg_data[0];
        REG_BASE_CHANNEL:      cfg.base_channel      <= cfg_data[3:0];
        REG_NOTES_PER_CHANNEL: cfg.notes_per_channel <= cfg_data[4:0];
        default:               cfg <= cfg;
      endcase
    end
  end

  mndt_front #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .note           (note),
    .duration_ticks (duration_ticks),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  mndt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mndt_back #(
    .NOTE_COUNT        (NOTE_COUNT),
    .TIME_BITS         (TIME_BITS),
    .MAX_OFFS_PER_TICK (MAX_OFFS_PER_TICK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status_byte (status_byte),
    .note_number (note_number),
    .velocity    (velocity),
    .last        (last)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for midi_note_duration_tracker_unit: directed and random
// note-on / tick items, every message checked against a scoreboard model of the note table
// depends on mndt_pkg and the rtl of the block

module testbench;
  import mndt_pkg::*;

  localparam int unsigned NOTE_COUNT        = 128;
  localparam int unsigned TIME_BITS         = 32;
  localparam int unsigned MAX_OFFS_PER_TICK = 64;
  localparam int unsigned SETTLE_CYCLES     = 3 * NOTE_COUNT + 64;
  localparam int unsigned CYCLE_LIMIT       = 2000000;
  localparam int unsigned PHASE_ITEMS       = 30;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } midi_msg_t;

  class midi_scoreboard;
    logic                 send_midi;
    logic [3:0]           base_channel;
    logic [4:0]           notes_per_channel;
    bit                   sounding [NOTE_COUNT];
    logic [TIME_BITS-1:0] expiry [NOTE_COUNT];
    logic [TIME_BITS-1:0] tick_now;
    midi_msg_t            expected_msgs [$];
    int                   errors;

    function new();
      send_midi         = 1'b1;
      base_channel      = 4'd0;
      notes_per_channel = 5'd0;
      tick_now          = '0;
      errors            = 0;
      for (int i = 0; i < NOTE_COUNT; i++) begin
        sounding[i] = 1'b0;
        expiry[i]   = '0;
      end
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function logic [3:0] channel_of(int unsigned n);
      int unsigned ch;
      if (notes_per_channel != 0) ch = n % notes_per_channel;
      else ch = base_channel;
      return ch[3:0] & CHAN_MASK;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_SEND_MIDI:         send_midi = val[0];
        REG_BASE_CHANNEL:      base_channel = val[3:0];
        REG_NOTES_PER_CHANNEL: notes_per_channel = val[4:0];
        default: ;
      endcase
    endfunction

    // predicts the messages caused by one accepted item
    function void take_item(logic m, logic [6:0] n, logic [15:0] d);
      midi_msg_t            msg;
      logic [TIME_BITS-1:0] age;
      int                   cleared;
      int                   count;
      int                   i;
      if (kind_t'(m) == KIND_NOTE_ON) begin
        if (n < NOTE_COUNT && !sounding[n]) begin
          sounding[n] = 1'b1;
          expiry[n]   = tick_now + TIME_BITS'(d);
          if (send_midi) begin
            msg.status = {ON_CODE, channel_of(n)};
            msg.note   = n;
            msg.vel    = ON_VELOCITY;
            msg.last   = 1'b1;
            expected_msgs.push_back(msg);
          end
        end
      end else begin
        tick_now = tick_now + 1'b1;
        cleared  = 0;
        count    = 0;
        for (i = 0; i < NOTE_COUNT && cleared < MAX_OFFS_PER_TICK; i++) begin
          age = tick_now - expiry[i];
          // strictly later, wrap-aware
          if (sounding[i] && age != 0 && !age[TIME_BITS-1]) begin
            sounding[i] = 1'b0;
            cleared++;
            if (send_midi) begin
              msg.status = {OFF_CODE, channel_of(i)};
              msg.note   = 7'(i);
              msg.vel    = OFF_VELOCITY;
              msg.last   = 1'b0;
              expected_msgs.push_back(msg);
              count++;
            end
          end
        end
        if (count > 0) begin
          msg      = expected_msgs.pop_back();
          msg.last = 1'b1;
          expected_msgs.push_back(msg);
        end
      end
    endfunction

    task check_message(logic [7:0] s, logic [6:0] n, logic [6:0] v, logic l);
      midi_msg_t want;
      if (expected_msgs.size() == 0) begin
        report($sformatf("unexpected message status %h note %0d vel %0d", s, n, v));
        return;
      end
      want = expected_msgs.pop_front();
      if (s !== want.status)
        report($sformatf("status_byte %h, expected %h", s, want.status));
      if (n !== want.note)
        report($sformatf("note_number %0d, expected %0d", n, want.note));
      if (v !== want.vel)
        report($sformatf("velocity %0d, expected %0d", v, want.vel));
      if (l !== want.last)
        report($sformatf("last %b, expected %b (note %0d)", l, want.last, want.note));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      mode;
  logic [6:0]                note;
  logic [15:0]               duration_ticks;
  logic                      out_valid;
  logic                      out_ready;
  logic [7:0]                status_byte;
  logic [6:0]                note_number;
  logic [6:0]                velocity;
  logic                      last;

  midi_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    stall_left = 0;
  bit             sender_gaps;
  bit             receiver_stalls;

  midi_note_duration_tracker_unit #(
    .NOTE_COUNT(NOTE_COUNT),
    .TIME_BITS(TIME_BITS),
    .MAX_OFFS_PER_TICK(MAX_OFFS_PER_TICK)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .note(note),
    .duration_ticks(duration_ticks),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status_byte(status_byte),
    .note_number(note_number),
    .velocity(velocity),
    .last(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output first: a message can never belong to an item taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_message(status_byte, note_number, velocity, last);
      if (in_valid && in_ready) sb.take_item(mode, note, duration_ticks);
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(negedge clk) begin
    if (!receiver_stalls) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send_item(kind_t k, logic [6:0] n, logic [15:0] d);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       = 1'b1;
    mode           = k;
    note           = n;
    duration_ticks = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_until_quiet();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(logic s, logic [3:0] b, logic [4:0] npc);
    cfg_write = 1'b1;
    if ($urandom_range(0, 1) == 1) begin
      cfg_index = REG_UNUSED;
      cfg_data  = 5'($urandom);
      @(negedge clk);
    end
    cfg_index = REG_SEND_MIDI;
    cfg_data  = {4'($urandom), s};
    @(negedge clk);
    cfg_index = REG_BASE_CHANNEL;
    cfg_data  = {1'($urandom), b};
    @(negedge clk);
    cfg_index = REG_NOTES_PER_CHANNEL;
    cfg_data  = npc;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic random_item();
    logic [15:0] d;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_item(KIND_TICK, 7'($urandom), 16'($urandom));
    end else begin
      if (pick < 85) d = 16'($urandom_range(0, 12));
      else if (pick < 96) d = 16'($urandom_range(13, 60));
      else d = 16'($urandom);
      send_item(KIND_NOTE_ON, 7'($urandom), d);
    end
  endtask

  task automatic run_phase(logic s, logic [3:0] b, logic [4:0] npc);
    int k;
    apply_settings(s, b, npc);
    for (k = 0; k < PHASE_ITEMS; k++) random_item();
    wait_until_quiet();
  endtask

  task automatic expire_burst(int count);
    int k;
    for (k = 0; k < count; k++) send_item(KIND_NOTE_ON, 7'(k), 16'd0);
    send_item(KIND_TICK, 7'd0, 16'd0);
  endtask

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_SEND_MIDI;
    cfg_data        = '0;
    in_valid        = 1'b0;
    mode            = KIND_NOTE_ON;
    note            = '0;
    duration_ticks  = '0;
    out_ready       = 1'b1;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset settings: base channel 0, messages on
    send_item(KIND_NOTE_ON, 7'd0, 16'd0);
    send_item(KIND_NOTE_ON, 7'd100, 16'hFFFF);
    send_item(KIND_NOTE_ON, 7'd0, 16'd5);
    send_item(KIND_NOTE_ON, 7'd127, 16'd1);
    send_item(KIND_NOTE_ON, 7'd64, 16'd2);
    send_item(KIND_TICK, 7'h7F, 16'hFFFF);
    send_item(KIND_TICK, 7'd0, 16'd0);
    send_item(KIND_TICK, 7'h55, 16'hAAAA);
    send_item(KIND_NOTE_ON, 7'd0, 16'd0);
    send_item(KIND_NOTE_ON, 7'd1, 16'd0);
    send_item(KIND_NOTE_ON, 7'd2, 16'd0);
    send_item(KIND_TICK, 7'h2A, 16'h5555);
    send_item(KIND_TICK, 7'd0, 16'd0);
    wait_until_quiet();

    // more expired notes than one tick may clear, channel above 15 wraps
    apply_settings(1'b1, 4'd5, 5'd17);
    expire_burst(70);
    send_item(KIND_TICK, 7'd0, 16'd0);
    wait_until_quiet();

    // the off limit holds in silent mode; the rest come out once messages are back on
    apply_settings(1'b0, 4'd2, 5'd0);
    expire_burst(70);
    wait_until_quiet();
    apply_settings(1'b1, 4'd2, 5'd0);
    send_item(KIND_TICK, 7'd0, 16'd0);
    wait_until_quiet();

    run_phase(1'b1, 4'd15, 5'd0);
    sender_gaps = ($urandom_range(0, 3) != 0);
    receiver_stalls = ($urandom_range(0, 3) != 0);
    run_phase(1'b1, 4'd7, 5'd16);
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    run_phase(1'b1, 4'd0, 5'd31);
    run_phase(1'b1, 4'd3, 5'd1);
    run_phase(1'b0, 4'd9, 5'd5);
    run_phase(1'b1, 4'd12, 5'd0);
    sender_gaps = ($urandom_range(0, 3) != 0);
    receiver_stalls = ($urandom_range(0, 3) != 0);
    run_phase(1'b1, 4'($urandom), 5'($urandom));
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    run_phase(1'($urandom), 4'($urandom), 5'($urandom));

    // closing stretch without idling on either side
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    run_phase(1'b1, 4'($urandom), 5'($urandom));

    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected messages never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
